@@ rtl/core/trta_pkg.sv @@
`default_nettype none

package trta_pkg;

    // formatted reading as it travels from the front to the character emitter
    typedef struct packed {
        logic       neg;
        logic [3:0] int_hund;
        logic [3:0] int_tens;
        logic [3:0] int_unit;
        logic [3:0] frac_tens;
        logic [3:0] frac_unit;
    } t_digits;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    localparam int RawW   = 12;
    localparam int MagW   = 12;
    localparam int HundW  = 14;   // hundredths of a degree, at most 12800
    localparam int QuotW  = 8;    // whole degrees, at most 128
    localparam int CharW  = 7;
    localparam int PosW   = 3;

    // floor(h / 100) == (h * 5243) >> 19 for every h below 2**14
    localparam logic [12:0] Recip100      = 13'd5243;
    localparam int          Recip100Shift = 19;
    // floor(v / 10) == (v * 205) >> 11 for every v below 128
    localparam logic [7:0]  Recip10       = 8'd205;
    localparam int          Recip10Shift  = 11;

    localparam logic [CharW-1:0] CHAR_PLUS  = 7'h2B;
    localparam logic [CharW-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CharW-1:0] CHAR_DOT   = 7'h2E;
    localparam logic [CharW-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CharW-1:0] CHAR_C     = 7'h43;

    localparam logic [PosW-1:0] POS_SIGN      = 3'd0;
    localparam logic [PosW-1:0] POS_INT_HUND  = 3'd1;
    localparam logic [PosW-1:0] POS_INT_TENS  = 3'd2;
    localparam logic [PosW-1:0] POS_INT_UNIT  = 3'd3;
    localparam logic [PosW-1:0] POS_DOT       = 3'd4;
    localparam logic [PosW-1:0] POS_FRAC_TENS = 3'd5;
    localparam logic [PosW-1:0] POS_FRAC_UNIT = 3'd6;
    localparam logic [PosW-1:0] POS_UNIT_C    = 3'd7;

    // splits a value below 100 into its tens and units digits
    function automatic logic [7:0] split_tens(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  rest;
        prod = {8'd0, v} * {7'd0, Recip10};
        tens = prod[14:Recip10Shift];
        rest = v - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);
        return {tens, rest[3:0]};
    endfunction

    function automatic logic [CharW-1:0] digit_char(input logic [3:0] d);
        return CHAR_ZERO + {3'd0, d};
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/trta_if.sv @@
`default_nettype none

interface trta_in_if;
    logic              valid;
    logic              ready;
    logic signed [11:0] raw_reading;

    modport source (output valid, output raw_reading, input ready);
    modport sink   (input valid, input raw_reading, output ready);
endinterface

interface trta_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] ascii_char;
    logic       last_char;

    modport source (output valid, output ascii_char, output last_char, input ready);
    modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

`default_nettype wire

@@ rtl/core/trta_front.sv @@
`default_nettype none

module trta_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    trta_in_if.sink                i_in,
    output trta_pkg::t_digits      o_rec,
    output logic                   o_rec_valid,
    input  wire logic              i_rec_ready
);
    import trta_pkg::*;

    logic                r_v1;
    logic                r_neg1;
    logic [HundW-1:0]    r_hund1;
    logic                r_v2;
    logic                r_neg2;
    logic [HundW-1:0]    r_hund2;
    logic [QuotW-1:0]    r_quot2;
    logic                r_v3;
    t_digits             r_rec3;

    logic                adv1, adv2, adv3;
    logic [RawW-1:0]     raw_bits;
    logic [MagW-1:0]     mag;
    logic [15:0]         scaled;
    logic [26:0]         quot_prod;
    logic [HundW-1:0]    frac_wide;
    logic [6:0]          int_rest;
    logic [7:0]          int_split;
    logic [7:0]          frac_split;
    logic                int_big;
    t_digits             n_rec;

    assign adv3 = !r_v3 || i_rec_ready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;
    assign i_in.ready = adv1;

    // magnitude: plain 12-bit negation, -2048 lands on 2048
    assign raw_bits = i_in.raw_reading;
    assign mag      = raw_bits[RawW-1] ? (~raw_bits + 1'b1) : raw_bits;
    // (25*m + 2) >> 2
    assign scaled   = ({4'd0, mag} << 4) + ({4'd0, mag} << 3) + {4'd0, mag} + 16'd2;

    assign quot_prod = {13'd0, r_hund1} * {14'd0, Recip100};

    always_comb begin
        int_big    = r_quot2 >= 8'd100;
        int_rest   = int_big ? (r_quot2[6:0] - 7'd100) : r_quot2[6:0];
        frac_wide  = r_hund2 - ({6'd0, r_quot2} << 6) - ({6'd0, r_quot2} << 5)
                   - ({6'd0, r_quot2} << 2);
        int_split  = split_tens(int_rest);
        frac_split = split_tens(frac_wide[6:0]);
        n_rec.neg       = r_neg2;
        n_rec.int_hund  = {3'd0, int_big};
        n_rec.int_tens  = int_split[7:4];
        n_rec.int_unit  = int_split[3:0];
        n_rec.frac_tens = frac_split[7:4];
        n_rec.frac_unit = frac_split[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_neg1  <= raw_bits[RawW-1];
            r_hund1 <= scaled[15:2];
        end
        if (adv2) begin
            r_neg2  <= r_neg1;
            r_hund2 <= r_hund1;
            r_quot2 <= quot_prod[Recip100Shift+QuotW-1:Recip100Shift];
        end
        if (adv3) begin
            r_rec3 <= n_rec;
        end
    end

    assign o_rec       = r_rec3;
    assign o_rec_valid = r_v3;

endmodule

`default_nettype wire

@@ rtl/core/trta_queue.sv @@
`default_nettype none

module trta_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire trta_pkg::t_digits i_push_rec,
    input  wire logic              i_push_valid,
    output trta_pkg::t_digits      o_pop_rec,
    input  wire logic              i_pop_ready,
    output trta_pkg::t_q_stat      o_stat
);
    import trta_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

    t_digits         r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_count;
    logic            push, pop;

    assign o_stat.full  = r_count == CW'(DEPTH);
    assign o_stat.empty = r_count == '0;
    assign push = i_push_valid && !o_stat.full;
    assign pop  = i_pop_ready && !o_stat.empty;
    assign o_pop_rec = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == LastIdx) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == LastIdx) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_rec;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/trta_back.sv @@
`default_nettype none

module trta_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire trta_pkg::t_digits i_rec,
    input  wire logic              i_rec_valid,
    output logic                   o_rec_ready,
    trta_out_if.source             o_out
);
    import trta_pkg::*;

    t_digits            r_rec;
    logic               r_busy;
    logic [PosW-1:0]    r_pos;
    logic               r_out_valid;
    logic [CharW-1:0]   r_char;
    logic               r_last;

    logic               adv, fin, load;
    logic [CharW-1:0]   n_char;

    assign adv  = !r_out_valid || o_out.ready;
    assign fin  = r_busy && adv && (r_pos == POS_UNIT_C);
    // next reading loads while the 'C' beat goes out, so runs abut
    assign o_rec_ready = !r_busy || fin;
    assign load = o_rec_ready && i_rec_valid;

    always_comb begin
        unique case (r_pos)
            POS_SIGN:      n_char = r_rec.neg ? CHAR_MINUS : CHAR_PLUS;
            POS_INT_HUND:  n_char = digit_char(r_rec.int_hund);
            POS_INT_TENS:  n_char = digit_char(r_rec.int_tens);
            POS_INT_UNIT:  n_char = digit_char(r_rec.int_unit);
            POS_DOT:       n_char = CHAR_DOT;
            POS_FRAC_TENS: n_char = digit_char(r_rec.frac_tens);
            POS_FRAC_UNIT: n_char = digit_char(r_rec.frac_unit);
            POS_UNIT_C:    n_char = CHAR_C;
            default:       n_char = CHAR_C;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= POS_SIGN;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
                r_pos  <= POS_SIGN;
            end else begin
                if (fin) begin
                    r_busy <= 1'b0;
                end
                if (adv && r_busy) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            if (adv) begin
                r_out_valid <= r_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rec <= i_rec;
        end
        if (adv) begin
            r_char <= n_char;
            r_last <= r_pos == POS_UNIT_C;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.ascii_char = r_char;
    assign o_out.last_char  = r_last;

endmodule

`default_nettype wire

@@ rtl/core/temperature_raw_to_ascii.sv @@
`default_nettype none

// Formats a signed 12-bit reading in 1/16 degree as the eight-beat ASCII run
// sign, three integer digits, '.', two fraction digits, 'C' (e.g. "+025.50C"),
// rounded half away from zero to hundredths; last_char marks the 'C' beat.
// The output sends one character per cycle while ready is high, so a steady
// stream of readings is paced by the one-character output port. Readings
// pass a 3-stage front pipeline (scale, divide by 100, split into digits)
// and then a queue of QUEUE_DEPTH formatted readings, so up to about
// QUEUE_DEPTH + 4 readings are taken back to back before the input stalls.
// When idle, a reading's first character passes the front stages, the queue,
// and the back record and character registers. QUEUE_DEPTH must be at least 2.
module temperature_raw_to_ascii #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    trta_in_if.sink     i_in,
    trta_out_if.source  o_out
);
    import trta_pkg::*;

    t_digits  front_rec;
    logic     front_valid;
    t_digits  queue_rec;
    t_q_stat  queue_stat;
    logic     back_ready;

    trta_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_rec       (front_rec),
        .o_rec_valid (front_valid),
        .i_rec_ready (!queue_stat.full)
    );

    trta_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_rec   (front_rec),
        .i_push_valid (front_valid),
        .o_pop_rec    (queue_rec),
        .i_pop_ready  (back_ready),
        .o_stat       (queue_stat)
    );

    trta_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (queue_rec),
        .i_rec_valid (!queue_stat.empty),
        .o_rec_ready (back_ready),
        .o_out       (o_out)
    );

`ifndef SYNTH
    a_last_is_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_char) |-> (o_out.ascii_char == CHAR_C))
        else $error("last beat is not 'C'");

    a_c_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ascii_char == CHAR_C) |-> o_out.last_char)
        else $error("'C' beat without last flag");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire
